>>> hw/rtl/ttst_pkg.sv
// shared types and constants for the touch track statistics block
`timescale 1ns / 1ps
package ttst_pkg;

  // event codes
  localparam logic [2:0] OP_DOWN    = 3'd0;
  localparam logic [2:0] OP_MOVE    = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_FORCE   = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam int TIME_BITS  = 32;
  localparam int SPEED_BITS = 27;
  localparam int DELAY_BITS = 16;
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 16'd200;

  // ms to s scale applied under the square root
  localparam int SCALE_BITS = 20;
  localparam int SCALE_IDX  = 5;
  localparam logic [SCALE_BITS-1:0] SCALE = 20'd1000000;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } spd_stat_t;

endpackage

>>> hw/rtl/ttst_speed.sv
// iterative speed unit: square, scale, bit-pair square root, restoring divide
`timescale 1ns / 1ps
module ttst_speed #(
  parameter int CW = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [CW-1:0]                       adx,
  input  logic [CW-1:0]                       ady,
  input  logic [ttst_pkg::TIME_BITS-1:0]      dt,
  output ttst_pkg::spd_stat_t                 stat,
  output logic [ttst_pkg::SPEED_BITS-1:0]     speed
);
  import ttst_pkg::*;

  localparam int D2W  = 2 * CW + 1;
  localparam int PW   = D2W + SCALE_BITS;
  localparam int RW   = PW + (PW % 2);
  localparam int RTW  = RW / 2;
  localparam int MAXI = (RTW > SCALE_BITS) ? RTW : SCALE_BITS;
  localparam int CNTW = $clog2(MAXI + 1);
  localparam int QW   = (RTW > SPEED_BITS) ? RTW : SPEED_BITS;

  typedef enum logic [2:0] {
    SP_IDLE, SP_SQA, SP_SQB, SP_MUL, SP_ROOT, SP_DIV, SP_DONE
  } sp_state_t;

  sp_state_t            state_r;
  logic [CW-1:0]        a_r, b_r;
  logic [TIME_BITS-1:0] dt_r;
  logic [D2W-1:0]       d2_r;
  logic [RW-1:0]        p_r;
  logic [RTW+2:0]       rem_r;
  logic [RTW-1:0]       root_r;
  logic [TIME_BITS:0]   drem_r;
  logic [CNTW-1:0]      cnt_r;

  logic [CW-1:0]        sq_op;
  logic [2*CW-1:0]      sq_prod;
  logic [RTW+2:0]       rem_s, trial;
  logic [TIME_BITS:0]   drem_s;
  logic [QW-1:0]        q_ext;

  assign sq_op   = (state_r == SP_SQB) ? b_r : a_r;
  assign sq_prod = sq_op * sq_op;
  assign rem_s   = {rem_r[RTW:0], p_r[RW-1:RW-2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign drem_s  = {drem_r[TIME_BITS-1:0], root_r[RTW-1]};
  assign q_ext   = QW'(root_r);

  assign stat.busy = (state_r != SP_IDLE);
  assign stat.done = (state_r == SP_DONE);
  assign speed = (q_ext > QW'(SPEED_MAX)) ? SPEED_MAX : q_ext[SPEED_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SP_IDLE;
    end else begin
      case (state_r)
        SP_IDLE: begin
          if (start) begin
            a_r     <= adx;
            b_r     <= ady;
            dt_r    <= dt;
            state_r <= SP_SQA;
          end
        end
        SP_SQA: begin
          d2_r    <= D2W'(sq_prod);
          state_r <= SP_SQB;
        end
        SP_SQB: begin
          d2_r    <= d2_r + D2W'(sq_prod);
          p_r     <= '0;
          cnt_r   <= CNTW'(SCALE_BITS - 1);
          state_r <= SP_MUL;
        end
        SP_MUL: begin
          // msb-first shift and add over the scale constant
          p_r <= {p_r[RW-2:0], 1'b0} + (SCALE[cnt_r[SCALE_IDX-1:0]] ? RW'(d2_r) : '0);
          if (cnt_r == '0) begin
            cnt_r   <= CNTW'(RTW - 1);
            rem_r   <= '0;
            root_r  <= '0;
            state_r <= SP_ROOT;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        SP_ROOT: begin
          if (rem_s >= trial) begin
            rem_r  <= rem_s - trial;
            root_r <= {root_r[RTW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_s;
            root_r <= {root_r[RTW-2:0], 1'b0};
          end
          p_r <= {p_r[RW-3:0], 2'b00};
          if (cnt_r == '0) begin
            cnt_r   <= CNTW'(RTW - 1);
            drem_r  <= '0;
            state_r <= SP_DIV;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        SP_DIV: begin
          // quotient bits shift into the root register
          if (drem_s >= {1'b0, dt_r}) begin
            drem_r <= drem_s - {1'b0, dt_r};
            root_r <= {root_r[RTW-2:0], 1'b1};
          end else begin
            drem_r <= drem_s;
            root_r <= {root_r[RTW-2:0], 1'b0};
          end
          if (cnt_r == '0) begin
            state_r <= SP_DONE;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        SP_DONE: begin
          state_r <= SP_IDLE;
        end
        default: begin
          state_r <= SP_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/touch_track_statistics.sv
// top level: track state, event sequencer and result beat
`timescale 1ns / 1ps
// Keeps the statistics of one touch track and returns one result beat per
// event. Events are taken one at a time: in_stall stays high from acceptance
// until the result beat has been taken. Each speed goes through a shared
// iterative unit (square of each axis difference, scale, then square root
// and divide). An event computes at most two speeds (segment and mean) and
// may also wait on an output stall. There is no clearing pass after reset.
module touch_track_statistics #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           in_op,
  input  logic signed [COORD_BITS-1:0]         in_x,
  input  logic signed [COORD_BITS-1:0]         in_y,
  input  logic [ttst_pkg::TIME_BITS-1:0]       in_stamp_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_active,
  output logic [COUNT_BITS-1:0]                out_point_count,
  output logic [ttst_pkg::TIME_BITS-1:0]       out_duration_ms,
  output logic                                 out_speeds_valid,
  output logic [ttst_pkg::SPEED_BITS-1:0]      out_peak_speed,
  output logic [ttst_pkg::SPEED_BITS-1:0]      out_mean_speed,
  output logic [COORD_BITS-1:0]                out_max_step_dx,
  output logic [COORD_BITS-1:0]                out_max_step_dy,
  output logic signed [COORD_BITS-1:0]         out_start_x,
  output logic signed [COORD_BITS-1:0]         out_start_y,
  output logic signed [COORD_BITS-1:0]         out_end_x,
  output logic signed [COORD_BITS-1:0]         out_end_y,
  input  logic                                 cfg_we,
  input  logic [ttst_pkg::DELAY_BITS-1:0]      cfg_wdata
);
  import ttst_pkg::*;

  localparam int CW = COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_SEGW, S_MEAN, S_MEANW, S_OUT
  } state_t;

  state_t                 state_r;
  logic [DELAY_BITS-1:0]  delay_r;
  logic                   active_r;
  logic [COUNT_BITS-1:0]  count_r;
  logic [CW-1:0]          head_x_r, head_y_r, tail_x_r, tail_y_r, pt_x_r, pt_y_r;
  logic [TIME_BITS-1:0]   head_t_r, tail_t_r, pt_t_r;
  logic [SPEED_BITS-1:0]  best_speed_r, mean_r;
  logic                   timed_r;
  logic [CW-1:0]          best_dx_r, best_dy_r;

  logic                   in_acc;
  logic [CW-1:0]          xa, xb, ya, yb, adx, ady;
  logic [CW:0]            xdiff, ydiff;
  logic [TIME_BITS-1:0]   ta, tb, tdiff;
  logic                   tpos, two_pts, spd_start;
  spd_stat_t              spd_stat;
  logic [SPEED_BITS-1:0]  spd_speed;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // one difference path serves the step and the head-to-tail span
  assign xa = (state_r == S_ADD) ? pt_x_r   : tail_x_r;
  assign xb = (state_r == S_ADD) ? tail_x_r : head_x_r;
  assign ya = (state_r == S_ADD) ? pt_y_r   : tail_y_r;
  assign yb = (state_r == S_ADD) ? tail_y_r : head_y_r;
  assign ta = (state_r == S_ADD) ? pt_t_r   : tail_t_r;
  assign tb = (state_r == S_ADD) ? tail_t_r : head_t_r;

  assign xdiff = {xa[CW-1], xa} - {xb[CW-1], xb};
  assign ydiff = {ya[CW-1], ya} - {yb[CW-1], yb};
  assign adx   = xdiff[CW] ? CW'(-xdiff) : xdiff[CW-1:0];
  assign ady   = ydiff[CW] ? CW'(-ydiff) : ydiff[CW-1:0];
  assign tdiff = ta - tb;
  assign tpos  = !tdiff[TIME_BITS-1] && (tdiff != '0);
  assign two_pts = (count_r > COUNT_BITS'(1));

  assign spd_start = ((state_r == S_ADD) && tpos) ||
                     ((state_r == S_MEAN) && two_pts && timed_r && tpos);

  ttst_speed #(.CW(CW)) u_speed (
    .clk   (clk),
    .rst_n (rst_n),
    .start (spd_start),
    .adx   (adx),
    .ady   (ady),
    .dt    (tdiff),
    .stat  (spd_stat),
    .speed (spd_speed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_we) begin
      delay_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= 1'b0;
      count_r      <= '0;
      head_x_r     <= '0;
      head_y_r     <= '0;
      head_t_r     <= '0;
      tail_x_r     <= '0;
      tail_y_r     <= '0;
      tail_t_r     <= '0;
      best_speed_r <= '0;
      timed_r      <= 1'b0;
      best_dx_r    <= '0;
      best_dy_r    <= '0;
      mean_r       <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_op)
              OP_DOWN, OP_CLEAR: begin
                state_r      <= S_MEAN;
                active_r     <= (in_op == OP_DOWN);
                count_r      <= (in_op == OP_DOWN) ? COUNT_BITS'(1) : '0;
                head_x_r     <= (in_op == OP_DOWN) ? in_x : '0;
                head_y_r     <= (in_op == OP_DOWN) ? in_y : '0;
                head_t_r     <= (in_op == OP_DOWN) ? in_stamp_ms : '0;
                tail_x_r     <= (in_op == OP_DOWN) ? in_x : '0;
                tail_y_r     <= (in_op == OP_DOWN) ? in_y : '0;
                tail_t_r     <= (in_op == OP_DOWN) ? in_stamp_ms : '0;
                best_speed_r <= '0;
                timed_r      <= 1'b0;
                best_dx_r    <= '0;
                best_dy_r    <= '0;
              end
              OP_MOVE, OP_RELEASE: begin
                state_r <= active_r ? S_ADD : S_MEAN;
                if (active_r) begin
                  pt_x_r   <= in_x;
                  pt_y_r   <= in_y;
                  pt_t_r   <= in_stamp_ms;
                  active_r <= (in_op == OP_MOVE);
                end
              end
              OP_FORCE: begin
                state_r <= (active_r && count_r == COUNT_BITS'(1)) ? S_ADD : S_MEAN;
                if (active_r) begin
                  active_r <= 1'b0;
                  // lone point is repeated after the release delay
                  if (count_r == COUNT_BITS'(1)) begin
                    pt_x_r  <= head_x_r;
                    pt_y_r  <= head_y_r;
                    pt_t_r  <= head_t_r + TIME_BITS'(delay_r);
                  end
                end
              end
              default: begin
                state_r <= S_MEAN;
              end
            endcase
          end
        end
        S_ADD: begin
          if (adx > best_dx_r) best_dx_r <= adx;
          if (ady > best_dy_r) best_dy_r <= ady;
          if (tdiff != '0) timed_r <= 1'b1;
          tail_x_r <= pt_x_r;
          tail_y_r <= pt_y_r;
          tail_t_r <= pt_t_r;
          if (count_r != '1) count_r <= count_r + 1'b1;
          state_r <= tpos ? S_SEGW : S_MEAN;
        end
        S_SEGW: begin
          if (spd_stat.done) begin
            if (spd_speed > best_speed_r) best_speed_r <= spd_speed;
            state_r <= S_MEAN;
          end
        end
        S_MEAN: begin
          mean_r  <= '0;
          state_r <= spd_start ? S_MEANW : S_OUT;
        end
        S_MEANW: begin
          if (spd_stat.done) begin
            mean_r  <= spd_speed;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = (state_r == S_OUT);
  assign out_active       = active_r;
  assign out_point_count  = count_r;
  assign out_speeds_valid = two_pts;
  assign out_duration_ms  = two_pts ? (tail_t_r - head_t_r) : '0;
  assign out_peak_speed   = two_pts ? best_speed_r : '0;
  assign out_mean_speed   = mean_r;
  assign out_max_step_dx  = two_pts ? best_dx_r : '0;
  assign out_max_step_dy  = two_pts ? best_dy_r : '0;
  assign out_start_x      = (count_r != '0) ? head_x_r : '0;
  assign out_start_y      = (count_r != '0) ? head_y_r : '0;
  assign out_end_x        = (count_r != '0) ? tail_x_r : '0;
  assign out_end_y        = (count_r != '0) ? tail_y_r : '0;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    spd_start |-> !spd_stat.busy)
    else $error("speed unit started while busy");
  a_active_has_point: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (count_r != '0))
    else $error("active track without points");
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    spd_stat.done |-> (state_r == S_SEGW || state_r == S_MEANW))
    else $error("speed result with nobody waiting");
  a_beat_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> (state_r == S_IDLE))
    else $error("result beat not retired");
`endif

endmodule
